### sv/prq_pkg.sv
// Shared types, constants and the entry ordering function of the priority ready queue.
`default_nettype none

package prq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = 5;  // occupancy field width, holds 0..CAPACITY

    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_SELECT = 2'd1;
    localparam logic [1:0] FN_CLEAR  = 2'd2;
    localparam logic [1:0] FN_NOP    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // id in the low byte, matching the stream payload layout
    typedef struct packed {
        logic [15:0] arrival;
        logic [7:0]  prio;
        logic [7:0]  id;
    } t_entry;

    typedef struct packed {
        logic load_in;   // latch the accepted item
        logic exec;      // insert / clear / status decision
        logic rd_en;     // read one slot of the scan
        logic swap_wr;   // move last entry into chosen slot
        logic out_load;  // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic scan_go;    // select on a non-empty queue
        logic scan_last;  // address being read is the last stored slot
    } t_dp_sts;

    // true when x runs before y
    function automatic logic runs_first(input t_entry x, input t_entry y);
        logic r;
        if (x.prio != y.prio) begin
            r = (x.prio < y.prio);
        end else if (x.arrival != y.arrival) begin
            r = (x.arrival < y.arrival);
        end else begin
            r = (x.id < y.id);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/prq_ctrl.sv
// Sequencer of the priority ready queue: handshakes and the select scan.
`default_nettype none

module prq_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  prq_pkg::t_dp_sts  i_sts,
    output prq_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_EXEC  = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FIN   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.scan_go ? S_SCAN : S_OUT;
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read data is compared this cycle
                n_state = S_FIN;
            end
            S_FIN: begin
                o_cmd.swap_wr = 1'b1;
                n_state       = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### sv/prq_dp.sv
// Datapath of the priority ready queue: entry memory, count, scan compare and result register.
`default_nettype none

module prq_dp (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  prq_pkg::t_dp_cmd               i_cmd,
    output prq_pkg::t_dp_sts               o_sts,
    input  wire  [1:0]                     i_func,
    input  wire  [31:0]                    i_entry,
    output logic [1:0]                     o_status,
    output logic [7:0]                     o_chosen_id,
    output logic [7:0]                     o_chosen_prio,
    output logic [15:0]                    o_chosen_arrival,
    output logic [prq_pkg::CNT_W-1:0]      o_occupancy
);

    prq_pkg::t_entry r_mem [prq_pkg::CAPACITY];

    logic [1:0]                  r_func;
    prq_pkg::t_entry             r_in;
    logic [prq_pkg::CNT_W-1:0]   r_count, n_count;
    logic [prq_pkg::IDX_W-1:0]   r_idx;
    logic                        r_rd_vld;
    logic [prq_pkg::IDX_W-1:0]   r_rd_idx;
    prq_pkg::t_entry             r_rd_data;
    prq_pkg::t_entry             r_best;
    logic [prq_pkg::IDX_W-1:0]   r_best_idx;
    prq_pkg::t_entry             r_last;
    logic [1:0]                  r_status;

    logic                        full;
    logic                        ins_wr;
    logic                        rd_is_last;
    logic                        take;
    logic                        wr_en;
    logic [prq_pkg::IDX_W-1:0]   wr_addr;
    prq_pkg::t_entry             wr_data;
    logic                        chosen_ok;

    assign full       = (r_count >= prq_pkg::CNT_W'(prq_pkg::CAPACITY));
    assign ins_wr     = i_cmd.exec && (r_func == prq_pkg::FN_INSERT) && !full;
    assign rd_is_last = ((prq_pkg::CNT_W'(r_rd_idx) + prq_pkg::CNT_W'(1)) == r_count);
    assign take       = (r_rd_idx == '0) || prq_pkg::runs_first(r_rd_data, r_best);

    assign o_sts.scan_go   = (r_func == prq_pkg::FN_SELECT) && (r_count != '0);
    assign o_sts.scan_last = ((prq_pkg::CNT_W'(r_idx) + prq_pkg::CNT_W'(1)) == r_count);

    // single write port: insert at the tail, or the swap on removal
    assign wr_en   = ins_wr || i_cmd.swap_wr;
    assign wr_addr = i_cmd.swap_wr ? r_best_idx : r_count[prq_pkg::IDX_W-1:0];
    assign wr_data = i_cmd.swap_wr ? r_last : r_in;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.exec && (r_func == prq_pkg::FN_CLEAR)) begin
            n_count = '0;
        end else if (ins_wr) begin
            n_count = r_count + prq_pkg::CNT_W'(1);
        end else if (i_cmd.swap_wr) begin
            n_count = r_count - prq_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_count  <= n_count;
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.load_in) begin
                r_idx <= '0;
            end else if (i_cmd.rd_en) begin
                r_idx <= r_idx + prq_pkg::IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_in   <= prq_pkg::t_entry'(i_entry);
        end
        if (i_cmd.rd_en) begin
            r_rd_idx <= r_idx;
        end
        if (i_cmd.exec) begin
            if ((r_func == prq_pkg::FN_INSERT) && full) begin
                r_status <= prq_pkg::ST_FULL;
            end else if ((r_func == prq_pkg::FN_SELECT) && (r_count == '0)) begin
                r_status <= prq_pkg::ST_EMPTY;
            end else begin
                r_status <= prq_pkg::ST_OK;
            end
        end
        // strict compare keeps the lowest slot on an exact tie
        if (r_rd_vld) begin
            if (take) begin
                r_best     <= r_rd_data;
                r_best_idx <= r_rd_idx;
            end
            if (rd_is_last) begin
                r_last <= r_rd_data;
            end
        end
    end

    assign chosen_ok = (r_func == prq_pkg::FN_SELECT) && (r_status == prq_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_status         <= r_status;
            o_chosen_id      <= chosen_ok ? r_best.id : 8'd0;
            o_chosen_prio    <= chosen_ok ? r_best.prio : 8'd0;
            o_chosen_arrival <= chosen_ok ? r_best.arrival : 16'd0;
            o_occupancy      <= r_count;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= prq_pkg::CNT_W'(prq_pkg::CAPACITY))
        else $error("entry count above capacity");

    a_swap_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap_wr |=> (r_count == ($past(r_count) - prq_pkg::CNT_W'(1))))
        else $error("removal did not decrement count");

    a_rd_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> (prq_pkg::CNT_W'(r_rd_idx) < r_count))
        else $error("scan read beyond stored entries");

    a_swap_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.swap_wr |-> ((r_count != '0) && (r_func == prq_pkg::FN_SELECT)))
        else $error("removal without a stored entry");
`endif

endmodule

`default_nettype wire

### sv/priority_ready_queue_core.sv
// Top level of the priority ready queue: stream ports, sequencer and datapath.
// Insert, clear and no-op items go from acceptance through the exec and output states, and a
// new item is taken only once the result is loaded. Select of n stored entries: the slot memory is
// read once per cycle, one port, so a select scans all n slots, then drains and swaps (no scan when empty).
// A finished result waits in the output register; the next item is taken meanwhile.
// Synchronous active-low reset empties the queue; slot contents stay undefined until written.
`default_nettype none

module priority_ready_queue_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // task_id[7:0], prio_level[15:8], arrive_time[31:16]
    input  wire  [1:0]  s_axis_tuser,   // func[1:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // chosen_id[7:0], chosen_prio[15:8],
                                        // chosen_arrival[31:16], occupancy[36:32], zero[39:37]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    prq_pkg::t_dp_cmd           cmd;
    prq_pkg::t_dp_sts           sts;
    logic [7:0]                 chosen_id;
    logic [7:0]                 chosen_prio;
    logic [15:0]                chosen_arrival;
    logic [prq_pkg::CNT_W-1:0]  occupancy;

    prq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    prq_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_func           (s_axis_tuser),
        .i_entry          (s_axis_tdata),
        .o_status         (m_axis_tuser),
        .o_chosen_id      (chosen_id),
        .o_chosen_prio    (chosen_prio),
        .o_chosen_arrival (chosen_arrival),
        .o_occupancy      (occupancy)
    );

    assign m_axis_tdata = {3'b000, occupancy, chosen_arrival, chosen_prio, chosen_id};

endmodule

`default_nettype wire

### verif/priority_ready_queue_core_test.sv
// Self-checking testbench for priority_ready_queue_core: directed table, then random traffic.
`timescale 1ns / 1ps

module priority_ready_queue_core_test;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [4:0]  occupancy;
    } t_sched_result;

    // one directed row; rows with reps > 1 bump the id on every repeat
    typedef struct packed {
        logic [1:0]  fn;
        logic [7:0]  id;
        logic [7:0]  prio;
        logic [15:0] arrival;
        logic [4:0]  reps;
        logic        typed;
        logic [1:0]  want_status;
        logic [4:0]  want_occ;
    } t_stim_row;

    localparam int NUM_ROWS     = 19;
    localparam int RANDOM_ITEMS = 1300;
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // task_id[7:0], prio_level[15:8], arrive_time[31:16]
    logic [1:0]  s_axis_tuser;   // func[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // chosen_id[7:0], chosen_prio[15:8], chosen_arrival[31:16],
                                 // occupancy[36:32]
    logic [1:0]  m_axis_tuser;   // status[1:0]

    priority_ready_queue_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // shadow copy of the ready queue
    prq_pkg::t_entry ready_slots [prq_pkg::CAPACITY];
    int unsigned     ready_count;

    t_sched_result pending_results [$];

    int  n_sent;
    int  n_checked;
    int  n_sel_hit;
    int  n_sel_empty;
    int  n_full_drop;
    int  n_mismatch;
    bit  calm;
    bit  hold_flag;

    t_stim_row directed_rows [NUM_ROWS] = '{
        '{prq_pkg::FN_SELECT, 8'hFF, 8'hFF, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_EMPTY, 5'd0},
        '{prq_pkg::FN_NOP,    8'hFF, 8'hFF, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_CLEAR,  8'hA5, 8'h5A, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_INSERT, 8'hFF, 8'h00, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd1},
        '{prq_pkg::FN_INSERT, 8'h00, 8'hFF, 16'h0000, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd2},
        '{prq_pkg::FN_INSERT, 8'h10, 8'h00, 16'hFFFE, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_INSERT, 8'h0F, 8'h00, 16'hFFFE, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_INSERT, 8'h0F, 8'h00, 16'hFFFE, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_INSERT, 8'h00, 8'h00, 16'h0000, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_SELECT, 8'h55, 8'hAA, 16'h5555, 5'd5,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_NOP,    8'h00, 8'h00, 16'h0000, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_SELECT, 8'h00, 8'h00, 16'h0000, 5'd1,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_SELECT, 8'hFF, 8'hFF, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_EMPTY, 5'd0},
        '{prq_pkg::FN_INSERT, 8'h20, 8'h80, 16'h1234, 5'd16, 1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_INSERT, 8'hAA, 8'h00, 16'h0000, 5'd1,  1'b1, prq_pkg::ST_FULL,  5'd16},
        '{prq_pkg::FN_NOP,    8'h00, 8'h00, 16'h0000, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd16},
        '{prq_pkg::FN_SELECT, 8'h00, 8'h00, 16'h0000, 5'd3,  1'b0, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_CLEAR,  8'hFF, 8'hFF, 16'hFFFF, 5'd1,  1'b1, prq_pkg::ST_OK,    5'd0},
        '{prq_pkg::FN_SELECT, 8'h00, 8'h00, 16'h0000, 5'd1,  1'b1, prq_pkg::ST_EMPTY, 5'd0}
    };

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("timeout: results still outstanding");
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        n_mismatch++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("%s: got 0x%0h, want 0x%0h (result %0d)",
                                      name, got, want, n_checked));
        end
    endtask

    // ordering key: priority, then arrival, then id, all ascending
    function automatic bit ranks_ahead(input prq_pkg::t_entry a, input prq_pkg::t_entry b);
        return {a.prio, a.arrival, a.id} < {b.prio, b.arrival, b.id};
    endfunction

    function automatic t_sched_result apply_item(input logic [1:0] fn,
                                                 input prq_pkg::t_entry e);
        t_sched_result res;
        int unsigned   best;
        res = '0;
        case (fn)
            prq_pkg::FN_INSERT: begin
                if (ready_count >= prq_pkg::CAPACITY) begin
                    res.status = prq_pkg::ST_FULL;
                    n_full_drop++;
                end else begin
                    ready_slots[ready_count] = e;
                    ready_count++;
                end
            end
            prq_pkg::FN_SELECT: begin
                if (ready_count == 0) begin
                    res.status = prq_pkg::ST_EMPTY;
                    n_sel_empty++;
                end else begin
                    best = 0;
                    for (int unsigned i = 1; i < ready_count; i++) begin
                        if (ranks_ahead(ready_slots[i], ready_slots[best])) begin
                            best = i;
                        end
                    end
                    res.id      = ready_slots[best].id;
                    res.prio    = ready_slots[best].prio;
                    res.arrival = ready_slots[best].arrival;
                    // last entry fills the hole
                    ready_slots[best] = ready_slots[ready_count - 1];
                    ready_count--;
                    n_sel_hit++;
                end
            end
            prq_pkg::FN_CLEAR: begin
                ready_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = ready_count[4:0];
        return res;
    endfunction

    // called at a falling edge; returns at the falling edge after the item is taken
    task automatic push_item(input logic [1:0] fn, input prq_pkg::t_entry e, input bit typed,
                             input t_sched_result typed_res);
        t_sched_result model_res;
        while (!calm && $urandom_range(99) < 22) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= e;
        s_axis_tuser  <= fn;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        model_res = apply_item(fn, e);
        pending_results.push_back(typed ? typed_res : model_res);
        n_sent++;
        @(negedge i_clk);
    endtask

    // result sink; one long hold-off lets the block back up into its input
    initial begin : result_sink
        bit held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_flag && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 22);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_sched_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, tdata 0x%0h status %0d",
                                          m_axis_tdata, m_axis_tuser));
            end else begin
                want = pending_results.pop_front();
                check_field("status", int'(m_axis_tuser), int'(want.status));
                check_field("chosen_id", int'(m_axis_tdata[7:0]), int'(want.id));
                check_field("chosen_prio", int'(m_axis_tdata[15:8]), int'(want.prio));
                check_field("chosen_arrival", int'(m_axis_tdata[31:16]),
                            int'(want.arrival));
                check_field("occupancy", int'(m_axis_tdata[36:32]), int'(want.occupancy));
            end
            n_checked++;
        end
    end

    initial begin : stimulus
        prq_pkg::t_entry e;
        t_sched_result   typed_res;
        logic [1:0]      fn;
        int              ins_pct;
        int              r;
        int              n_directed;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = prq_pkg::FN_NOP;
        ready_count   = 0;
        calm          = 1'b0;
        hold_flag     = 1'b0;
        n_sent        = 0;
        n_checked     = 0;
        n_sel_hit     = 0;
        n_sel_empty   = 0;
        n_full_drop   = 0;
        n_mismatch    = 0;
        ins_pct       = 50;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            for (int k = 0; k < directed_rows[i].reps; k++) begin
                e.id      = directed_rows[i].id + k[7:0];
                e.prio    = directed_rows[i].prio;
                e.arrival = directed_rows[i].arrival;
                typed_res = '{directed_rows[i].want_status, 8'h00, 8'h00, 16'h0000,
                              directed_rows[i].want_occ};
                push_item(directed_rows[i].fn, e, directed_rows[i].typed, typed_res);
            end
        end
        n_directed = n_sent;

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            // fill bias changes every burst so the queue swings between empty and full
            if (k % 50 == 0) begin
                case ($urandom_range(3))
                    0:       ins_pct = 25;
                    1:       ins_pct = 50;
                    2:       ins_pct = 75;
                    default: ins_pct = 92;
                endcase
            end
            calm = (k >= 500 && k < 750);
            if (k == 200) hold_flag = 1'b1;

            r = $urandom_range(99);
            if (r < 2)                             fn = prq_pkg::FN_CLEAR;
            else if (r < 5)                        fn = prq_pkg::FN_NOP;
            else if ($urandom_range(99) < ins_pct) fn = prq_pkg::FN_INSERT;
            else                                   fn = prq_pkg::FN_SELECT;

            // narrow ranges make ties on priority, arrival and id common
            r = $urandom_range(9);
            if (r < 5)       e.prio = 8'($urandom_range(3));
            else if (r == 5) e.prio = $urandom_range(1) ? 8'hFF : 8'h00;
            else             e.prio = 8'($urandom_range(255));
            e.arrival = ($urandom_range(9) < 4) ? 16'($urandom_range(3))
                                                : 16'($urandom_range(65535));
            e.id      = ($urandom_range(1) == 0) ? 8'($urandom_range(3))
                                                 : 8'($urandom_range(255));

            push_item(fn, e, 1'b0, '0);
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d items sent (%0d from the directed table), %0d results checked",
                 n_sent, n_directed, n_checked);
        $display("selects: %0d returned an entry, %0d on empty; %0d inserts dropped on full",
                 n_sel_hit, n_sel_empty, n_full_drop);
        if (n_mismatch == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
